@@ sv/qrsc_pkg.sv @@
package qrsc_pkg;

   localparam int COUNT_BITS = 16;
   localparam int REV_BITS   = 32;

   localparam int PPR_W    = 15;
   localparam int GLITCH_W = 8;
   localparam int SCALE_W  = 10;

   localparam int PULSE_W = 16;
   localparam int REVS_W  = 32;
   localparam int TOTAL_W = 47;
   localparam int SPEED_W = 32;

   localparam int DIFF_W = COUNT_BITS + 2;
   localparam int PROD_W = DIFF_W + SCALE_W + 1;
   localparam int SPD_W  = (PROD_W > SPEED_W + 1) ? PROD_W : SPEED_W + 1;
   localparam int TOT_W  = (REV_BITS + COUNT_BITS + 1 > TOTAL_W) ?
                           REV_BITS + COUNT_BITS + 1 : TOTAL_W;

   localparam longint LIMIT_CAP = (64'sd1 <<< (COUNT_BITS - 1)) - 64'sd1;

   localparam int REQ_FIELDS_W = 3;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = PULSE_W + REVS_W + TOTAL_W + SPEED_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int ADDR_W     = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_PPR    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_GLITCH = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_SCALE  = 2'd2;

   localparam logic [PPR_W-1:0]    PPR_RESET    = 15'd1024;
   localparam logic [GLITCH_W-1:0] GLITCH_RESET = 8'd80;
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = 10'd10;

   typedef struct packed {
      logic [PPR_W-1:0]    pulses_per_rev;
      logic [GLITCH_W-1:0] glitch_cycles;
      logic [SCALE_W-1:0]  speed_scale;
   } cfg_type;

   typedef struct packed {
      logic pin_a;
      logic pin_b;
      logic window_end;
      logic clear_counts;
   } item_type;

   typedef struct packed {
      logic signed [PULSE_W-1:0] pulse_count;
      logic signed [REVS_W-1:0]  revolutions;
      logic signed [TOTAL_W-1:0] total_pulses;
      logic signed [SPEED_W-1:0] speed;
   } result_type;

endpackage

@@ sv/quadrature_revolution_speed_counter.sv @@
// Two-times quadrature encoder counter. Each transfer on the request stream carries one
// sample of pins A and B and yields exactly one transfer on the response stream with the
// pulse count, revolution count, total pulses and the latest window speed. A new sample is
// taken every cycle while the response side is not stalled; a response is presented
// after its request transfer, through an input register and a result register, and
// the count state takes one update per sample, which sets that rate. Registers: 0x0
// pulses per revolution, 0x4 glitch filter cycles, 0x8 windows per second.
module quadrature_revolution_speed_counter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // pin_a, pin_b, clear_counts, zero fill
   input  logic [qrsc_pkg::REQ_DATA_W-1:0] req_tdata,
   // window_end
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pulse_count, revolutions, total_pulses, speed, zero fill
   output logic [qrsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [qrsc_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [qrsc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [qrsc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import qrsc_pkg::*;

   cfg_type               cfg;
   item_type              item_ff;
   logic                  in_valid_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  advance;
   logic                  a_now;
   logic                  a_next;
   logic                  b_now;
   logic                  b_next;
   result_type            result;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.pin_a        <= req_tdata[0];
         item_ff.pin_b        <= req_tdata[1];
         item_ff.clear_counts <= req_tdata[2];
         item_ff.window_end   <= req_tlast;
      end
      if (advance) begin
         rsp_data_ff <= RSP_DATA_W'({result.speed, result.total_pulses,
                                     result.revolutions, result.pulse_count});
      end
   end

   qrsc_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   qrsc_filter u_filter_a (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .raw           (item_ff.pin_a),
      .glitch_cycles (cfg.glitch_cycles),
      .level_now     (a_now),
      .level_next    (a_next)
   );

   qrsc_filter u_filter_b (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .raw           (item_ff.pin_b),
      .glitch_cycles (cfg.glitch_cycles),
      .level_now     (b_now),
      .level_next    (b_next)
   );

   qrsc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .cfg          (cfg),
      .a_now        (a_now),
      .a_next       (a_next),
      .b_next       (b_next && (b_now || !b_now)),
      .window_end   (item_ff.window_end),
      .clear_counts (item_ff.clear_counts),
      .result       (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ sv/qrsc_filter.sv @@
module qrsc_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          raw,
   input  logic [qrsc_pkg::GLITCH_W-1:0] glitch_cycles,
   output logic                          level_now,
   output logic                          level_next
);
   import qrsc_pkg::*;

   logic                level_ff;
   logic                level_in;
   logic [GLITCH_W-1:0] stable_ff;
   logic [GLITCH_W-1:0] stable_in;

   always_comb begin
      level_in  = level_ff;
      stable_in = '0;
      if (raw != level_ff) begin
         if (stable_ff >= glitch_cycles) begin
            level_in = raw;
         end else begin
            stable_in = stable_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= 1'b0;
         stable_ff <= '0;
      end else if (enable) begin
         level_ff  <= level_in;
         stable_ff <= stable_in;
      end
   end

   assign level_now  = level_ff;
   assign level_next = level_in;

endmodule

@@ sv/qrsc_core.sv @@
module qrsc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  qrsc_pkg::cfg_type    cfg,
   input  logic                 a_now,
   input  logic                 a_next,
   input  logic                 b_next,
   input  logic                 window_end,
   input  logic                 clear_counts,
   output qrsc_pkg::result_type result
);
   import qrsc_pkg::*;

   logic signed [COUNT_BITS-1:0] count_ff;
   logic signed [COUNT_BITS-1:0] count_in;
   logic signed [REV_BITS-1:0]   rev_ff;
   logic signed [REV_BITS-1:0]   rev_in;
   logic signed [COUNT_BITS-1:0] mark_ff;
   logic signed [COUNT_BITS-1:0] mark_in;
   logic signed [SPEED_W-1:0]    speed_ff;
   logic signed [SPEED_W-1:0]    speed_in;

   logic [COUNT_BITS-1:0]        lim;
   logic signed [DIFF_W-1:0]     lim_s;
   logic signed [DIFF_W-1:0]     half_s;
   logic signed [DIFF_W-1:0]     stepped;
   logic signed [COUNT_BITS-1:0] count_step;
   logic signed [REV_BITS-1:0]   rev_step;
   logic signed [DIFF_W-1:0]     diff;
   logic signed [SPD_W-1:0]      prod;
   logic signed [TOT_W-1:0]      total;

   localparam logic signed [SPD_W-1:0] SPD_MAX = {{(SPD_W-SPEED_W+1){1'b0}},
                                                  {(SPEED_W-1){1'b1}}};
   localparam logic signed [SPD_W-1:0] SPD_MIN = {{(SPD_W-SPEED_W+1){1'b1}},
                                                  {(SPEED_W-1){1'b0}}};

   always_comb begin
      if (cfg.pulses_per_rev == '0) begin
         lim = COUNT_BITS'(1);
      end else if (longint'(cfg.pulses_per_rev) > LIMIT_CAP) begin
         lim = COUNT_BITS'(LIMIT_CAP);
      end else begin
         lim = COUNT_BITS'(cfg.pulses_per_rev);
      end
      lim_s  = signed'({2'b00, lim});
      half_s = lim_s >>> 1;

      // A rise of A counts up, a fall counts down; B high reverses the direction.
      count_step = count_ff;
      rev_step   = rev_ff;
      stepped    = DIFF_W'(count_ff);
      if (a_next != a_now) begin
         if (a_next ^ b_next) begin
            stepped = DIFF_W'(count_ff) + DIFF_W'(1);
         end else begin
            stepped = DIFF_W'(count_ff) - DIFF_W'(1);
         end
         if (stepped >= lim_s) begin
            count_step = '0;
            rev_step   = rev_ff + REV_BITS'(1);
         end else if (stepped <= -lim_s) begin
            count_step = '0;
            rev_step   = rev_ff - REV_BITS'(1);
         end else begin
            count_step = stepped[COUNT_BITS-1:0];
         end
      end

      diff = DIFF_W'(count_step) - DIFF_W'(mark_ff);
      if (diff > half_s) begin
         diff = diff - lim_s;
      end else if (diff < -half_s) begin
         diff = diff + lim_s;
      end
      prod = SPD_W'(diff) * SPD_W'(signed'({1'b0, cfg.speed_scale}));

      mark_in  = mark_ff;
      speed_in = speed_ff;
      if (window_end) begin
         mark_in = count_step;
         if (prod > SPD_MAX) begin
            speed_in = SPD_MAX[SPEED_W-1:0];
         end else if (prod < SPD_MIN) begin
            speed_in = SPD_MIN[SPEED_W-1:0];
         end else begin
            speed_in = prod[SPEED_W-1:0];
         end
      end

      count_in = clear_counts ? '0 : count_step;
      rev_in   = clear_counts ? '0 : rev_step;

      total = TOT_W'(rev_in) * TOT_W'(lim_s) + TOT_W'(count_in);

      result.pulse_count  = PULSE_W'(count_in);
      result.revolutions  = REVS_W'(rev_in);
      result.total_pulses = total[TOTAL_W-1:0];
      result.speed        = speed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rev_ff   <= '0;
         mark_ff  <= '0;
         speed_ff <= '0;
      end else if (enable) begin
         count_ff <= count_in;
         rev_ff   <= rev_in;
         mark_ff  <= mark_in;
         speed_ff <= speed_in;
      end
   end

endmodule

@@ sv/qrsc_regs.sv @@
module qrsc_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [qrsc_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [qrsc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [qrsc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output qrsc_pkg::cfg_type               cfg
);
   import qrsc_pkg::*;

   cfg_type              cfg_ff;
   logic [REG_IDX_W-1:0] index;
   logic                 wr_en;

   assign index = csr_paddr[ADDR_W-1:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulses_per_rev <= PPR_RESET;
         cfg_ff.glitch_cycles  <= GLITCH_RESET;
         cfg_ff.speed_scale    <= SCALE_RESET;
      end else if (wr_en) begin
         case (index)
            REG_PPR:    cfg_ff.pulses_per_rev <= csr_pwdata[PPR_W-1:0];
            REG_GLITCH: cfg_ff.glitch_cycles  <= csr_pwdata[GLITCH_W-1:0];
            REG_SCALE:  cfg_ff.speed_scale    <= csr_pwdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_PPR:    csr_prdata = CSR_DATA_W'(cfg_ff.pulses_per_rev);
         REG_GLITCH: csr_prdata = CSR_DATA_W'(cfg_ff.glitch_cycles);
         REG_SCALE:  csr_prdata = CSR_DATA_W'(cfg_ff.speed_scale);
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/qrsc_checker.sv @@
module qrsc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [qrsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [qrsc_pkg::ADDR_W-1:0]     csr_paddr,
   input logic [qrsc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [qrsc_pkg::CSR_DATA_W-1:0] csr_prdata
);
   import qrsc_pkg::*;

   logic [PPR_W-1:0]          ppr_ff;
   logic signed [PPR_W+1:0]   lim;
   logic signed [PPR_W+1:0]   pc;

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff <= PPR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[ADDR_W-1:2] == REG_PPR) begin
         ppr_ff <= csr_pwdata[PPR_W-1:0];
      end
   end

   // A lowered limit may leave the count above it, so only the counter range is fixed.
   assign lim = (PPR_W+2)'(LIMIT_CAP);
   assign pc  = (PPR_W+2)'(signed'(rsp_tdata[PULSE_W-1:0]));

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request stalled while response side is ready");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pc > -lim) && (pc < lim))
      else $error("pulse count outside the counter range");

   a_ppr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && !csr_pwrite && csr_paddr[ADDR_W-1:2] == REG_PPR
      |-> csr_prdata == CSR_DATA_W'(ppr_ff))
      else $error("pulses per revolution reads back wrong");

endmodule

bind quadrature_revolution_speed_counter qrsc_checker u_qrsc_checker (.*);

@@ tb/tb_quadrature_revolution_speed_counter.sv @@
`timescale 1ns / 1ps

module tb_quadrature_revolution_speed_counter;
   import qrsc_pkg::*;

   class counter_scoreboard;
      bit [PPR_W-1:0]    ppr;
      bit [GLITCH_W-1:0] glitch;
      bit [SCALE_W-1:0]  scale;

      bit                filt_a;
      bit                filt_b;
      bit [7:0]          hold_a;
      bit [7:0]          hold_b;
      int                count;
      logic signed [31:0] revs;
      int                count_at_window;
      int                speed;

      result_type        expected_counts[$];
      int                errors;

      function new();
         ppr = PPR_RESET;
         glitch = GLITCH_RESET;
         scale = SCALE_RESET;
         filt_a = 0;
         filt_b = 0;
         hold_a = 0;
         hold_b = 0;
         count = 0;
         revs = 0;
         count_at_window = 0;
         speed = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_counts.size();
      endfunction

      function void filter_pin(input bit raw, inout bit level, inout bit [7:0] cnt);
         if (raw == level) begin
            cnt = 0;
         end else if (cnt >= glitch) begin
            level = raw;
            cnt = 0;
         end else begin
            cnt = cnt + 8'd1;
         end
      endfunction

      function void note_sample(item_type it);
         bit         old_a;
         int         lim;
         int         step;
         int         n;
         int         diff;
         longint     sp;
         longint     tot;
         result_type e;
         old_a = filt_a;
         lim = (ppr == 0) ? 1 : int'(ppr);
         step = 0;
         filter_pin(it.pin_a, filt_a, hold_a);
         filter_pin(it.pin_b, filt_b, hold_b);
         if (filt_a != old_a) begin
            step = filt_a ? 1 : -1;
            if (filt_b) step = -step;
         end
         if (step != 0) begin
            n = count + step;
            if (n >= lim) begin
               count = 0;
               revs = revs + 32'sd1;
            end else if (n <= -lim) begin
               count = 0;
               revs = revs - 32'sd1;
            end else begin
               count = n;
            end
         end
         if (it.window_end) begin
            diff = count - count_at_window;
            if (diff > lim / 2) diff = diff - lim;
            else if (diff < -(lim / 2)) diff = diff + lim;
            count_at_window = count;
            sp = longint'(diff) * longint'(scale);
            if (sp > 64'sd2147483647) sp = 64'sd2147483647;
            else if (sp < -64'sd2147483648) sp = -64'sd2147483648;
            speed = int'(sp);
         end
         if (it.clear_counts) begin
            count = 0;
            revs = 0;
         end
         tot = longint'(revs) * longint'(lim) + longint'(count);
         e.pulse_count = count[PULSE_W-1:0];
         e.revolutions = revs;
         e.total_pulses = tot[TOTAL_W-1:0];
         e.speed = speed;
         expected_counts.push_back(e);
      endfunction

      function void compare_field(string name, longint exp_val, longint act_val);
         if (exp_val != act_val) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_counts(logic [RSP_DATA_W-1:0] data);
         result_type got;
         result_type e;
         got.pulse_count = data[0 +: PULSE_W];
         got.revolutions = data[PULSE_W +: REVS_W];
         got.total_pulses = data[PULSE_W + REVS_W +: TOTAL_W];
         got.speed = data[PULSE_W + REVS_W + TOTAL_W +: SPEED_W];
         if (expected_counts.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual %h", $time, data);
            errors++;
            return;
         end
         e = expected_counts.pop_front();
         compare_field("pulse_count", e.pulse_count, got.pulse_count);
         compare_field("revolutions", e.revolutions, got.revolutions);
         compare_field("total_pulses", e.total_pulses, got.total_pulses);
         compare_field("speed", e.speed, got.speed);
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]     csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   counter_scoreboard sb = new();
   int                send_idle_pct = 17;
   int                take_idle_pct = 76;
   int                samples_sent = 0;
   bit [1:0]          quad_phase = 0;
   bit                forward = 1;

   quadrature_revolution_speed_counter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= take_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_counts(rsp_tdata);
   end

   task automatic send_sample(bit a, bit b, bit w, bit c);
      item_type              it;
      logic [REQ_DATA_W-1:0] d;
      it.pin_a = a;
      it.pin_b = b;
      it.window_end = w;
      it.clear_counts = c;
      d = '0;
      d[0] = a;
      d[1] = b;
      d[2] = c;
      if (samples_sent < 400) begin
         send_idle_pct = 17;
         take_idle_pct = 76;
      end else if (samples_sent < 780) begin
         send_idle_pct = 76;
         take_idle_pct = 17;
      end else begin
         send_idle_pct = 0;
         take_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= w;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(it);
      samples_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_PPR:    sb.ppr = value[PPR_W-1:0];
         REG_GLITCH: sb.glitch = value[GLITCH_W-1:0];
         REG_SCALE:  sb.scale = value[SCALE_W-1:0];
         default: ;
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_encoder(int ppr, int glitch, int scale, int n);
      int left;
      int hold;
      int k;
      bit a;
      bit b;
      wait_idle();
      write_reg(REG_PPR, ppr);
      write_reg(REG_GLITCH, glitch);
      write_reg(REG_SCALE, scale);
      left = n;
      while (left > 0) begin
         if ($urandom_range(0, 99) < 10) begin
            send_sample($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                        $urandom_range(0, 1));
            left--;
         end else begin
            if ($urandom_range(0, 99) < 15) forward = !forward;
            quad_phase = forward ? quad_phase + 2'd1 : quad_phase - 2'd1;
            if ($urandom_range(0, 3) == 0) hold = $urandom_range(1, glitch + 1);
            else hold = glitch + 1 + $urandom_range(0, 2);
            for (k = 0; k < hold && left > 0; k++) begin
               a = (quad_phase == 2'd1) || (quad_phase == 2'd2);
               b = quad_phase[1];
               if ($urandom_range(0, 19) == 0) begin
                  if ($urandom_range(0, 1) == 1) a = !a;
                  else b = !b;
               end
               send_sample(a, b, $urandom_range(0, 7) == 0, $urandom_range(0, 59) == 0);
               left--;
            end
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(1, 1, 1, 1);
      send_sample(1, 1, 1, 1);
      send_sample(0, 0, 0, 0);

      wait_idle();
      write_reg(REG_GLITCH, 0);
      write_reg(REG_PPR, 0);
      write_reg(REG_SCALE, 1000);
      send_sample(1, 0, 0, 0);
      send_sample(0, 0, 0, 0);
      send_sample(1, 1, 1, 0);
      send_sample(0, 1, 0, 0);
      send_sample(0, 1, 1, 1);

      wait_idle();
      write_reg(REG_PPR, 32767);
      write_reg(REG_SCALE, 1023);
      send_sample(1, 0, 0, 0);
      send_sample(1, 1, 0, 0);
      send_sample(0, 1, 0, 0);
      send_sample(0, 0, 0, 0);
      send_sample(1, 0, 1, 0);

      // The count now stands above the lowered limit, so the next step wraps.
      wait_idle();
      write_reg(REG_PPR, 2);
      write_reg(REG_SCALE, 0);
      send_sample(1, 1, 0, 0);
      send_sample(0, 1, 0, 0);
      send_sample(0, 0, 1, 0);
      send_sample(0, 0, 1, 1);

      run_encoder(1, 0, 1, 150);
      run_encoder(5, 1, 1000, 180);
      run_encoder(2, 3, 0, 150);
      run_encoder(32767, 255, 1023, 300);
      run_encoder(9, 0, 513, 170);
      run_encoder(4, 2, 37, 150);

      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/qrsc_pkg.sv
sv/qrsc_filter.sv
sv/qrsc_core.sv
sv/qrsc_regs.sv
sv/quadrature_revolution_speed_counter.sv
sv/qrsc_checker.sv
tb/tb_quadrature_revolution_speed_counter.sv
